>>> design/dste_pkg.sv
// Package: table size, opcodes, add outcomes, controller states and shared structs.
package dste_pkg;

    localparam int SLOTS = 3;

    localparam int ADDR_W   = 64;
    localparam int TIME_W   = 32;
    localparam int EXPIRY_W = TIME_W + 1;
    localparam int SLOT_W   = 2;
    localparam int OP_W     = 2;
    localparam int ACT_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_TICK  = 2'd1,
        OP_RESET = 2'd2,
        OP_READ  = 2'd3
    } t_opcode;

    typedef enum logic [ACT_W-1:0] {
        ACT_MATCH  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_OLDEST = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MIN
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [ADDR_W-1:0] addr_hi;
        logic [ADDR_W-1:0] addr_lo;
        logic [TIME_W-1:0] lifetime;
        logic [TIME_W-1:0] now_seconds;
        logic [SLOT_W-1:0] read_slot;
    } t_item;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [ACT_W-1:0]    add_action;
        logic                any_expired;
        logic [EXPIRY_W-1:0] next_expiry;
        logic                entry_valid;
        logic [ADDR_W-1:0]   entry_addr_hi;
        logic [ADDR_W-1:0]   entry_addr_lo;
        logic [EXPIRY_W-1:0] entry_expiry;
        logic [TIME_W-1:0]   entry_arrival;
    } t_result;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_dp_cmd;

endpackage

>>> design/dste_if.sv
// Valid/ready channel interfaces for request and response beats.
interface dste_in_if import dste_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    logic [ADDR_W-1:0]   addr_hi;
    logic [ADDR_W-1:0]   addr_lo;
    logic [TIME_W-1:0]   lifetime;
    logic [TIME_W-1:0]   now_seconds;
    logic [SLOT_W-1:0]   read_slot;

    modport source (output valid, opcode, addr_hi, addr_lo, lifetime, now_seconds, read_slot,
                    input ready);
    modport sink   (input valid, opcode, addr_hi, addr_lo, lifetime, now_seconds, read_slot,
                    output ready);
endinterface

interface dste_out_if import dste_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   slot;
    logic [ACT_W-1:0]    add_action;
    logic                any_expired;
    logic [EXPIRY_W-1:0] next_expiry;
    logic                entry_valid;
    logic [ADDR_W-1:0]   entry_addr_hi;
    logic [ADDR_W-1:0]   entry_addr_lo;
    logic [EXPIRY_W-1:0] entry_expiry;
    logic [TIME_W-1:0]   entry_arrival;

    modport source (output valid, slot, add_action, any_expired, next_expiry, entry_valid,
                    entry_addr_hi, entry_addr_lo, entry_expiry, entry_arrival,
                    input ready);
    modport sink   (input valid, slot, add_action, any_expired, next_expiry, entry_valid,
                    entry_addr_hi, entry_addr_lo, entry_expiry, entry_arrival,
                    output ready);
endinterface

>>> design/dns_server_table_with_expiry_top.sv
// Top level: server address table with lifetime expiry and oldest-arrival replacement.
// The controller walks capture, table update and least-expiry stages, holds in the last
// stage while a result is unread, and takes no new beat until that result is loaded.
// Reset (i_rst_n low at a rising edge, synchronous) clears the controller, every
// slot address, arrival and expiry, and drops any pending result.
module dns_server_table_with_expiry_top import dste_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dste_in_if.sink    i_in,
    dste_out_if.source o_out
);

    t_dp_cmd w_cmd;
    t_item   w_item;
    t_result w_result;

    // Gather the request beat into one struct for the datapath
    always_comb begin
        w_item.opcode      = i_in.opcode;
        w_item.addr_hi     = i_in.addr_hi;
        w_item.addr_lo     = i_in.addr_lo;
        w_item.lifetime    = i_in.lifetime;
        w_item.now_seconds = i_in.now_seconds;
        w_item.read_slot   = i_in.read_slot;
    end

    // Controller: owns the handshake and steps the datapath
    dste_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    // Datapath: table registers, slot choice, expiry sweep and result register
    dste_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (w_item),
        .o_result (w_result)
    );

    // Drive the response beat straight from the result register
    assign o_out.slot          = w_result.slot;
    assign o_out.add_action    = w_result.add_action;
    assign o_out.any_expired   = w_result.any_expired;
    assign o_out.next_expiry   = w_result.next_expiry;
    assign o_out.entry_valid   = w_result.entry_valid;
    assign o_out.entry_addr_hi = w_result.entry_addr_hi;
    assign o_out.entry_addr_lo = w_result.entry_addr_lo;
    assign o_out.entry_expiry  = w_result.entry_expiry;
    assign o_out.entry_arrival = w_result.entry_arrival;

endmodule

>>> design/dste_ctrl.sv
// Controller state machine: sequences capture, table update and result load.
module dste_ctrl import dste_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_load;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_load   = (r_state == S_MIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: n_state = S_MIN;
            S_MIN: begin
                if (w_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = (r_state == S_IDLE);
        o_cmd.capture = w_accept;
        o_cmd.exec    = (r_state == S_EXEC);
        o_cmd.load    = w_load;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        priority if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_EXEC)
        else $error("accepted beat did not start execution");

    a_exec_to_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |=> r_state == S_MIN)
        else $error("execution did not advance to result stage");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_out_valid && r_state == S_IDLE)
        else $error("result load did not raise output valid");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !w_load)
        else $error("pending result overwritten");

endmodule

>>> design/dste_dp.sv
// Datapath: slot table, add/tick/reset/read update and least-expiry search.
module dste_dp import dste_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_cmd i_cmd,
    input  t_item   i_item,
    output t_result o_result
);

    // Captured request
    t_item r_item;

    // Slot table
    logic [ADDR_W-1:0]   r_addr_hi [SLOTS];
    logic [ADDR_W-1:0]   r_addr_lo [SLOTS];
    logic [EXPIRY_W-1:0] r_expiry  [SLOTS];
    logic [TIME_W-1:0]   r_arrival [SLOTS];

    // Per-item result held between update and least-expiry stage
    t_result r_part, n_part;
    t_result r_result, n_result;

    logic [SLOTS-1:0]    w_sel;
    logic [ACT_W-1:0]    w_action;
    logic [SLOT_W-1:0]   w_slot;
    logic [SLOTS-1:0]    w_expire;
    logic [EXPIRY_W-1:0] w_new_expiry;
    logic [EXPIRY_W-1:0] w_least;
    logic [SLOTS-1:0]    w_oldest;

    assign w_new_expiry = EXPIRY_W'(r_item.lifetime) + EXPIRY_W'(r_item.now_seconds);

    // Choose the slot for an add: match, then first free, then oldest arrival
    always_comb begin
        int   best;
        logic found;
        best     = 0;
        found    = 1'b0;
        w_sel    = '0;
        w_oldest = '0;
        w_action = ACT_OLDEST;
        for (int i = 1; i < SLOTS; i++) begin
            if (r_arrival[i] < r_arrival[best]) best = i;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (i == best) w_oldest[i] = 1'b1;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (!found && r_addr_hi[i] == r_item.addr_hi && r_addr_lo[i] == r_item.addr_lo) begin
                w_sel[i] = 1'b1;
                w_action = ACT_MATCH;
                found    = 1'b1;
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (!found && r_expiry[i] == '0) begin
                w_sel[i] = 1'b1;
                w_action = ACT_FREE;
                found    = 1'b1;
            end
        end
        if (!found) w_sel = w_oldest;
    end

    always_comb begin
        w_slot = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (w_sel[i]) w_slot = SLOT_W'(i);
        end
    end

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_expire[i] = (r_expiry[i] != '0) && (r_expiry[i] <= {1'b0, r_item.now_seconds});
        end
    end

    // Partial result assembled during the update cycle
    always_comb begin
        n_part             = '0;
        n_part.add_action  = ACT_NONE;
        unique case (t_opcode'(r_item.opcode))
            OP_ADD: begin
                n_part.slot       = w_slot;
                n_part.add_action = w_action;
            end
            OP_TICK:  n_part.any_expired = |w_expire;
            OP_RESET: n_part.any_expired = 1'b0;
            OP_READ: begin
                n_part.slot = r_item.read_slot;
                for (int i = 0; i < SLOTS; i++) begin
                    if (r_item.read_slot == SLOT_W'(i) && (i < (1 << SLOT_W))) begin
                        n_part.entry_valid   = (r_expiry[i] != '0);
                        n_part.entry_addr_hi = r_addr_hi[i];
                        n_part.entry_addr_lo = r_addr_lo[i];
                        n_part.entry_expiry  = r_expiry[i];
                        n_part.entry_arrival = r_arrival[i];
                    end
                end
            end
            default: n_part.add_action = ACT_NONE;
        endcase
    end

    // Least nonzero expiry over the updated table
    always_comb begin
        w_least = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (r_expiry[i] != '0 && (w_least == '0 || r_expiry[i] < w_least)) begin
                w_least = r_expiry[i];
            end
        end
    end

    // Merge the least expiry into the held partial result
    always_comb begin
        n_result             = r_part;
        n_result.next_expiry = w_least;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_item   <= i_item;
        if (i_cmd.exec)    r_part   <= n_part;
        if (i_cmd.load)    r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_addr_hi[i] <= '0;
                r_addr_lo[i] <= '0;
                r_expiry[i]  <= '0;
                r_arrival[i] <= '0;
            end
        end else if (i_cmd.exec) begin
            for (int i = 0; i < SLOTS; i++) begin
                unique case (t_opcode'(r_item.opcode))
                    OP_ADD: begin
                        if (w_sel[i]) begin
                            r_addr_hi[i] <= r_item.addr_hi;
                            r_addr_lo[i] <= r_item.addr_lo;
                            r_arrival[i] <= r_item.now_seconds;
                            r_expiry[i]  <= w_new_expiry;
                        end
                    end
                    OP_TICK: begin
                        if (w_expire[i]) r_expiry[i] <= '0;
                    end
                    OP_RESET: r_expiry[i] <= '0;
                    OP_READ:  r_expiry[i] <= r_expiry[i];
                    default:  r_expiry[i] <= r_expiry[i];
                endcase
            end
        end
    end

    assign o_result = r_result;

    a_add_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> $onehot(w_sel))
        else $error("add slot choice not one-hot");

    a_add_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && r_item.opcode == OP_ADD |=> r_expiry[w_slot] == $past(w_new_expiry))
        else $error("add did not store expiry");

    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && r_item.opcode == OP_RESET |=> w_least == '0)
        else $error("reset-all left a live entry");

endmodule

>>> verif/dns_server_table_with_expiry_top_tb.sv
// Testbench for the server address table: directed and random beats checked against a predictor.
module dns_server_table_with_expiry_top_tb;
    import dste_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Stall budget: the longest receiver hold-off plus several times the slowest beat.
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int POOL_SIZE    = 6;

    logic i_clk;
    logic i_rst_n;

    dste_in_if  in_ch ();
    dste_out_if out_ch ();

    dns_server_table_with_expiry_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Shadow copy of the table, kept in step with every accepted request beat.
    logic [ADDR_W-1:0]   shadow_hi  [SLOTS];
    logic [ADDR_W-1:0]   shadow_lo  [SLOTS];
    logic [EXPIRY_W-1:0] shadow_exp [SLOTS];
    logic [TIME_W-1:0]   shadow_arr [SLOTS];

    t_result replies_due [$];

    int err_count     = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_token    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int stall_cycles  = 0;

    // Random traffic runs on a slowly advancing clock and a small pool of addresses,
    // so that matches, replacements and expiries keep happening.
    logic [TIME_W-1:0]   traffic_now;
    logic [2*ADDR_W-1:0] addr_pool [POOL_SIZE];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one request to the shadow table and return the reply it must produce.
    function automatic t_result predict_table_op(t_item it);
        t_result             r;
        int                  idx;
        logic [EXPIRY_W-1:0] least;
        r            = '0;
        r.add_action = ACT_NONE;
        idx          = -1;
        least        = '0;
        case (t_opcode'(it.opcode))
            OP_ADD: begin
                // Look for the same address first, live or expired.
                for (int i = 0; i < SLOTS && idx < 0; i++) begin
                    if (shadow_hi[i] == it.addr_hi && shadow_lo[i] == it.addr_lo) begin
                        idx          = i;
                        r.add_action = ACT_MATCH;
                    end
                end
                // Then the lowest free slot.
                for (int i = 0; i < SLOTS && idx < 0; i++) begin
                    if (shadow_exp[i] == '0) begin
                        idx          = i;
                        r.add_action = ACT_FREE;
                    end
                end
                // Else evict the oldest arrival; strict compare keeps ties on the lowest slot.
                if (idx < 0) begin
                    idx = 0;
                    for (int i = 1; i < SLOTS; i++) begin
                        if (shadow_arr[i] < shadow_arr[idx]) idx = i;
                    end
                    r.add_action = ACT_OLDEST;
                end
                shadow_hi[idx]  = it.addr_hi;
                shadow_lo[idx]  = it.addr_lo;
                shadow_arr[idx] = it.now_seconds;
                shadow_exp[idx] = {1'b0, it.lifetime} + {1'b0, it.now_seconds};
                r.slot          = idx[SLOT_W-1:0];
            end
            OP_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (shadow_exp[i] != '0 && shadow_exp[i] <= {1'b0, it.now_seconds}) begin
                        shadow_exp[i] = '0;
                        r.any_expired = 1'b1;
                    end
                end
            end
            OP_RESET: begin
                for (int i = 0; i < SLOTS; i++) shadow_exp[i] = '0;
            end
            default: begin
                r.slot = it.read_slot;
                // Out-of-range slot leaves every entry field zero.
                if (int'(it.read_slot) < SLOTS) begin
                    r.entry_valid   = (shadow_exp[it.read_slot] != '0);
                    r.entry_addr_hi = shadow_hi[it.read_slot];
                    r.entry_addr_lo = shadow_lo[it.read_slot];
                    r.entry_expiry  = shadow_exp[it.read_slot];
                    r.entry_arrival = shadow_arr[it.read_slot];
                end
            end
        endcase
        for (int i = 0; i < SLOTS; i++) begin
            if (shadow_exp[i] != '0 && (least == '0 || shadow_exp[i] < least))
                least = shadow_exp[i];
        end
        r.next_expiry = least;
        return r;
    endfunction

    function automatic t_item make_item(t_opcode op, logic [ADDR_W-1:0] hi,
                                        logic [ADDR_W-1:0] lo, logic [TIME_W-1:0] life,
                                        logic [TIME_W-1:0] now, logic [SLOT_W-1:0] rs);
        t_item it;
        it.opcode      = op;
        it.addr_hi     = hi;
        it.addr_lo     = lo;
        it.lifetime    = life;
        it.now_seconds = now;
        it.read_slot   = rs;
        return it;
    endfunction

    task automatic check_field(string name, logic [127:0] want, logic [127:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: mismatch on %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // Offer one request beat, after a random gap, and hold it until accepted.
    // Valid stays high on return so back-to-back beats never drop it.
    task automatic send_item(t_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= it.opcode;
        in_ch.addr_hi     <= it.addr_hi;
        in_ch.addr_lo     <= it.addr_lo;
        in_ch.lifetime    <= it.lifetime;
        in_ch.now_seconds <= it.now_seconds;
        in_ch.read_slot   <= it.read_slot;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Predict on each accepted request beat; compare each accepted reply beat
    // against the oldest prediction.
    always @(posedge i_clk) begin : scoreboard
        t_item   seen;
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                seen.opcode      = in_ch.opcode;
                seen.addr_hi     = in_ch.addr_hi;
                seen.addr_lo     = in_ch.addr_lo;
                seen.lifetime    = in_ch.lifetime;
                seen.now_seconds = in_ch.now_seconds;
                seen.read_slot   = in_ch.read_slot;
                replies_due.push_back(predict_table_op(seen));
            end
            if (out_ch.valid && out_ch.ready) begin
                got.slot          = out_ch.slot;
                got.add_action    = out_ch.add_action;
                got.any_expired   = out_ch.any_expired;
                got.next_expiry   = out_ch.next_expiry;
                got.entry_valid   = out_ch.entry_valid;
                got.entry_addr_hi = out_ch.entry_addr_hi;
                got.entry_addr_lo = out_ch.entry_addr_lo;
                got.entry_expiry  = out_ch.entry_expiry;
                got.entry_arrival = out_ch.entry_arrival;
                if (replies_due.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected reply, expected none actual %0h", $time, got);
                end else begin
                    want = replies_due.pop_front();
                    check_field("slot", 128'(want.slot), 128'(got.slot));
                    check_field("add_action", 128'(want.add_action), 128'(got.add_action));
                    check_field("any_expired", 128'(want.any_expired), 128'(got.any_expired));
                    check_field("next_expiry", 128'(want.next_expiry), 128'(got.next_expiry));
                    check_field("entry_valid", 128'(want.entry_valid), 128'(got.entry_valid));
                    check_field("entry_addr_hi", 128'(want.entry_addr_hi),
                                128'(got.entry_addr_hi));
                    check_field("entry_addr_lo", 128'(want.entry_addr_lo),
                                128'(got.entry_addr_lo));
                    check_field("entry_expiry", 128'(want.entry_expiry),
                                128'(got.entry_expiry));
                    check_field("entry_arrival", 128'(want.entry_arrival),
                                128'(got.entry_arrival));
                end
            end
        end
    end

    // Reply side: drop ready at random, or for a long counted hold-off when a
    // test bumps the hold token.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: end the run when no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("dns_server_table_with_expiry_top test failed");
            $finish;
        end
    end

    // Addresses are zero after reset, so a read shows zeros and an add of the
    // zero address lands on slot 0 as a match.
    task automatic test_zero_address_after_reset();
        send_item(make_item(OP_READ, '0, '0, '0, '0, 2'd0));
        send_item(make_item(OP_ADD, '0, '0, 32'd100, 32'd10, 2'd0));
    endtask

    // Fill the free slots, store a zero expiry that leaves its slot free, then
    // force oldest-arrival replacement.
    task automatic test_fill_and_replace();
        send_item(make_item(OP_ADD, '1, '1, '1, '1, 2'd3));
        send_item(make_item(OP_ADD, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                            32'd0, 32'd0, 2'd1));
        send_item(make_item(OP_ADD, 64'h2001_0db8_0000_0001, 64'h0000_0000_0000_00b0,
                            32'd5, 32'd3, 2'd2));
        send_item(make_item(OP_ADD, 64'h2001_0db8_0000_0002, 64'h0000_0000_0000_00c0,
                            32'd50, 32'd20, 2'd0));
        send_item(make_item(OP_ADD, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                            32'd7, 32'd30, 2'd1));
    endtask

    // Ticks: nothing due, expiry equal to now, a repeat that frees nothing, a
    // match on an expired entry, and the largest now.
    task automatic test_expiry_tick();
        send_item(make_item(OP_TICK, '1, '0, '1, 32'd0, 2'd3));
        send_item(make_item(OP_TICK, '0, '1, '0, 32'd37, 2'd0));
        send_item(make_item(OP_TICK, '0, '0, '0, 32'd37, 2'd0));
        send_item(make_item(OP_ADD, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                            32'd1, 32'd40, 2'd2));
        send_item(make_item(OP_TICK, '0, '0, '0, '1, 2'd1));
    endtask

    // Clear all entries, refill with equal arrivals and check the tie goes to slot 0.
    task automatic test_reset_all_and_tie();
        send_item(make_item(OP_RESET, 64'haaaa_5555_aaaa_5555, 64'h5555_aaaa_5555_aaaa,
                            32'hdead_beef, 32'hffff_0000, 2'd2));
        send_item(make_item(OP_ADD, 64'hd, 64'h1, 32'd9, 32'd500, 2'd0));
        send_item(make_item(OP_ADD, 64'he, 64'h2, 32'd9, 32'd500, 2'd0));
        send_item(make_item(OP_ADD, 64'hf, 64'h3, 32'd9, 32'd500, 2'd0));
        send_item(make_item(OP_ADD, 64'h7, 64'h4, 32'd9, 32'd500, 2'd0));
    endtask

    // Read every slot and the one index past the table.
    task automatic test_read_range();
        for (int i = 0; i < 4; i++)
            send_item(make_item(OP_READ, {$urandom, $urandom}, {$urandom, $urandom},
                                $urandom, $urandom, i[SLOT_W-1:0]));
    endtask

    // Mostly well-formed traffic on a pooled address set and an advancing clock,
    // with a quarter of fully random beats mixed in.
    task automatic test_random_traffic(int count, int send_pct, int recv_pct);
        t_item it;
        int    pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        addr_pool[0]  = '0;
        addr_pool[1]  = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = {$urandom, $urandom, $urandom, $urandom};
        // Start low most of the time, sometimes close to the top of the clock.
        if ($urandom_range(0, 2) == 0)
            traffic_now = 32'hffff_ffff - $urandom_range(0, 2000);
        else
            traffic_now = $urandom_range(0, 1000);
        for (int n = 0; n < count; n++) begin
            it = make_item(t_opcode'($urandom_range(0, 3)), {$urandom, $urandom},
                           {$urandom, $urandom}, $urandom, $urandom,
                           SLOT_W'($urandom_range(0, 3)));
            if ($urandom_range(0, 99) >= 25) begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    it.opcode = OP_ADD;
                else if (pick < 70)
                    it.opcode = OP_TICK;
                else if (pick < 95)
                    it.opcode = OP_READ;
                else
                    it.opcode = OP_RESET;
                // Refresh one pool entry now and then so new addresses keep arriving.
                if ($urandom_range(0, 19) == 0)
                    addr_pool[$urandom_range(2, POOL_SIZE - 1)] =
                        {$urandom, $urandom, $urandom, $urandom};
                {it.addr_hi, it.addr_lo} = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
                if ($urandom_range(0, 4) != 0)
                    it.lifetime = $urandom_range(0, 40);
                traffic_now    = traffic_now + $urandom_range(0, 6);
                it.now_seconds = traffic_now;
            end
            send_item(it);
        end
    endtask

    // Hold the reply side off for a long stretch while requests keep coming,
    // so the block fills and stalls its input.
    task automatic test_input_backpressure();
        hold_token <= hold_token + 1;
        test_random_traffic(100, 0, 0);
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.opcode      <= OP_ADD;
        in_ch.addr_hi     <= '0;
        in_ch.addr_lo     <= '0;
        in_ch.lifetime    <= '0;
        in_ch.now_seconds <= '0;
        in_ch.read_slot   <= '0;
        for (int i = 0; i < SLOTS; i++) begin
            shadow_hi[i]  = '0;
            shadow_lo[i]  = '0;
            shadow_exp[i] = '0;
            shadow_arr[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_address_after_reset();
        test_fill_and_replace();
        test_expiry_tick();
        test_reset_all_and_tie();
        test_read_range();
        test_random_traffic(400, 36, 67);
        test_random_traffic(400, 67, 36);
        test_random_traffic(400, 0, 0);
        test_input_backpressure();

        // Drop valid, drain the outstanding replies, then watch for strays.
        in_ch.valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("dns_server_table_with_expiry_top test passed");
        else
            $display("dns_server_table_with_expiry_top test failed");
        $finish;
    end

endmodule

>>> dns_server_table_with_expiry_top.f
design/dste_pkg.sv
design/dste_if.sv
design/dste_ctrl.sv
design/dste_dp.sv
design/dns_server_table_with_expiry_top.sv
verif/dns_server_table_with_expiry_top_tb.sv
